// ===== sv/fcsg_pkg.sv =====
// shared types and constants for the filled circle span generator
package fcsg_pkg;

    // field widths fixed by the item formats
    localparam int COORD_W  = 10;
    localparam int RAD_W    = 6;
    localparam int SPAN_W   = 12;
    localparam int OFS_W    = 9;
    localparam int DEC_W    = 11;
    localparam int CNT_W    = 7;

    // a circle never gives more results than this
    localparam logic [CNT_W-1:0] RESULT_LIMIT = 7'd64;

    // input item
    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [RAD_W-1:0]   radius;
    } t_in;

    // result item
    typedef struct packed {
        logic signed [SPAN_W-1:0] wide_row_below;
        logic signed [SPAN_W-1:0] wide_row_above;
        logic signed [SPAN_W-1:0] wide_left;
        logic signed [SPAN_W-1:0] wide_right;
        logic signed [SPAN_W-1:0] narrow_row_below;
        logic signed [SPAN_W-1:0] narrow_row_above;
        logic signed [SPAN_W-1:0] narrow_left;
        logic signed [SPAN_W-1:0] narrow_right;
        logic                     last_of_circle;
    } t_out;

    // one queued circle, radius already clamped
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [RAD_W-1:0]   r;
    } t_job;

    // head of the job queue as seen by the walker
    typedef struct packed {
        logic valid;
        t_job job;
    } t_head;

endpackage

// ===== sv/fcsg_front.sv =====
// front end: takes circle transfers, clamps the radius and queues the jobs
module fcsg_front #(
    parameter int MAX_RADIUS = 63
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  fcsg_pkg::t_in  i_data,
    output logic           o_stall,
    output fcsg_pkg::t_head o_head,
    input  logic           i_pop
);

    fcsg_pkg::t_job r_ent [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic [fcsg_pkg::RAD_W-1:0] rad_c;

    // radius saturation
    always_comb begin
        if (32'(i_data.radius) > MAX_RADIUS) begin
            rad_c = fcsg_pkg::RAD_W'(MAX_RADIUS);
        end else begin
            rad_c = i_data.radius;
        end
    end

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp] <= '{cx: i_data.center_x, cy: i_data.center_y, r: rad_c};
        end
    end

    // queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.job   = r_ent[r_rp];

endmodule

// ===== sv/fcsg_back.sv =====
// back end: runs the circle walk and drives the result register
module fcsg_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fcsg_pkg::t_head i_head,
    output logic            o_pop,
    output logic            o_valid,
    output fcsg_pkg::t_out  o_data,
    input  logic            i_stall
);

    localparam int OW = fcsg_pkg::OFS_W;
    localparam int DW = fcsg_pkg::DEC_W;
    localparam int SW = fcsg_pkg::SPAN_W;

    logic                       r_busy;
    logic signed [OW-1:0]       r_along, r_across;
    logic signed [DW-1:0]       r_dec;
    logic [fcsg_pkg::CNT_W-1:0] r_cnt;
    logic [fcsg_pkg::COORD_W-1:0] r_cx, r_cy;
    logic [fcsg_pkg::RAD_W-1:0] r_r;
    logic                       r_valid;
    fcsg_pkg::t_out             r_out;

    logic signed [OW-1:0]       n_along, n_across;
    logic signed [DW-1:0]       n_dec;
    logic [fcsg_pkg::CNT_W-1:0] n_cnt;
    logic signed [DW-1:0]       along_x, across_x, rad_x;
    logic                       done;
    logic                       advance;
    logic signed [SW-1:0]       cx_s, cy_s, al_s, ac_s;

    assign o_pop   = !r_busy && i_head.valid;
    assign advance = r_busy && (!r_valid || !i_stall);

    // three-way decision step
    always_comb begin
        along_x  = DW'(r_along);
        across_x = DW'(r_across);
        rad_x    = DW'({1'b0, r_r});
        n_along  = r_along;
        n_across = r_across;
        priority if (r_dec >= (along_x <<< 1)) begin
            n_dec   = r_dec - (along_x <<< 1) - DW'(1);
            n_along = r_along + OW'(1);
        end else if (r_dec < ((rad_x - across_x) <<< 1)) begin
            n_dec    = r_dec + (across_x <<< 1) - DW'(1);
            n_across = r_across - OW'(1);
        end else begin
            n_dec    = r_dec + ((across_x - along_x - DW'(1)) <<< 1);
            n_across = r_across - OW'(1);
            n_along  = r_along + OW'(1);
        end
        n_cnt = r_cnt + fcsg_pkg::CNT_W'(1);
        done  = (n_across < n_along) || (n_cnt >= fcsg_pkg::RESULT_LIMIT);
    end

    // span endpoints from the current offsets
    assign cx_s = SW'({1'b0, r_cx});
    assign cy_s = SW'({1'b0, r_cy});
    assign al_s = SW'(r_along);
    assign ac_s = SW'(r_across);

    // walker control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (advance && done) begin
            r_busy <= 1'b0;
        end
    end

    // walker datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cx     <= i_head.job.cx;
            r_cy     <= i_head.job.cy;
            r_r      <= i_head.job.r;
            r_along  <= '0;
            r_across <= OW'({1'b0, i_head.job.r});
            r_dec    <= DW'({1'b0, i_head.job.r}) - DW'(1);
            r_cnt    <= '0;
        end else if (advance) begin
            r_along  <= n_along;
            r_across <= n_across;
            r_dec    <= n_dec;
            r_cnt    <= n_cnt;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.wide_row_below   <= cy_s + al_s;
            r_out.wide_row_above   <= cy_s - al_s;
            r_out.wide_left        <= cx_s - ac_s;
            r_out.wide_right       <= cx_s + ac_s;
            r_out.narrow_row_below <= cy_s + ac_s;
            r_out.narrow_row_above <= cy_s - ac_s;
            r_out.narrow_left      <= cx_s - al_s;
            r_out.narrow_right     <= cx_s + al_s;
            r_out.last_of_circle   <= done;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

endmodule

// ===== sv/filled_circle_span_generator.sv =====
// top level of the filled circle span generator
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------
//  circle   | in        | i_valid / o_stall  | i_data (center, radius)
//  spans    | out       | o_valid / i_stall  | o_data (four spans, last)
//
// a circle of n results keeps the walker busy loading the job from the
// queue, then one step of the walk per result; n is at most radius+1.
// the front queue holds two circles and stalls only when both are waiting.
// a stalled result holds in the output register and freezes the walk.
// synchronous active-low reset empties the queue and the output register.
module filled_circle_span_generator #(
    parameter int MAX_RADIUS = 63
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  fcsg_pkg::t_in  i_data,
    output logic           o_stall,
    output logic           o_valid,
    output fcsg_pkg::t_out o_data,
    input  logic           i_stall
);

    fcsg_pkg::t_head head;
    logic            pop;

    // transfer acceptance and job queue
    fcsg_front #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_head  (head),
        .i_pop   (pop)
    );

    // circle walk and result register
    fcsg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule
